[sv/scsa_pkg.sv]
// ----------------------------------------------------------------------------
// scsa_pkg
// Types and constants shared by the slab allocator modules.
// ----------------------------------------------------------------------------
package scsa_pkg;
   localparam int CLASS_COUNT = 7;
   localparam int CLASS_W = 3;
   localparam int MIN_SHIFT = 5;
   localparam int SLOT_W = 7;
   localparam int ADDR_W = 18;
   localparam int SIZE_W = 16;
   localparam int THR_W = 7;
   localparam int CFO_W = 13;
   localparam int STATUS_W = 2;
   localparam logic [SIZE_W-1:0] MAX_REQUEST = 16'd2048;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_NO_PAGE = 2'd2
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE = 1'b1
   } mode_type;

   function automatic logic [SLOT_W-1:0] full_count(input logic [CLASS_W-1:0] c);
      logic [SLOT_W:0] v;
      v = 8'd128 >> c;
      return SLOT_W'(v - 8'd1);
   endfunction

   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [CLASS_W-1:0] c;
      c = 3'd6;
      if (size <= 16'd32) c = 3'd0;
      else if (size <= 16'd64) c = 3'd1;
      else if (size <= 16'd128) c = 3'd2;
      else if (size <= 16'd256) c = 3'd3;
      else if (size <= 16'd512) c = 3'd4;
      else if (size <= 16'd1024) c = 3'd5;
      return c;
   endfunction
endpackage

[sv/scsa_if.sv]
// ----------------------------------------------------------------------------
// scsa channel interfaces
// Valid/ready channels for requests, responses and the register write.
// ----------------------------------------------------------------------------
interface scsa_req_if import scsa_pkg::*; ();
   logic valid;
   logic ready;
   logic mode;
   logic [SIZE_W-1:0] request_size;
   logic [ADDR_W-1:0] object_address;
   modport source (output valid, mode, request_size, object_address, input ready);
   modport sink (input valid, mode, request_size, object_address, output ready);
endinterface

interface scsa_rsp_if import scsa_pkg::*; ();
   logic valid;
   logic ready;
   logic [ADDR_W-1:0] granted_address;
   logic [STATUS_W-1:0] status;
   logic page_released;
   modport source (output valid, granted_address, status, page_released, input ready);
   modport sink (input valid, granted_address, status, page_released, output ready);
endinterface

interface scsa_csr_if import scsa_pkg::*; ();
   logic valid;
   logic ready;
   logic [THR_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[sv/scsa_ram.sv]
// ----------------------------------------------------------------------------
// scsa_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/size_class_slab_allocator.sv]
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// Slab allocator with seven power-of-two size classes over a page pool.
// ----------------------------------------------------------------------------
// One request is processed at a time, and each request gives one response word.
// Page records sit in one RAM (in-use, class, free count, free head, next page).
// Object links sit in a second RAM. Both RAMs have a registered read. Steps from
// acceptance to the response state:
// - An allocate of a bad size goes straight to the response state.
// - An allocate that pops from the head page of its class reads that page
//   record, reads the object link and writes the page record back. Each
//   further page walked in the class list adds a page record read.
// - Claiming a page scans the pool from page 0, one page at a time. It then
//   threads the free list one object at a time (1 to 127 objects) and pops
//   the first object.
// - A free reads the page record, then writes it and the object link. An
//   ignored free responds after the read, and a free whose page is out of
//   range goes straight to the response state.
// - A free that releases a page walks the class list one page at a time. It
//   reads and rewrites the previous page record to relink a page that is not
//   at the head.
// Requests are accepted only in the idle state. A response that waits in the
// output register holds the next response in its final state. After reset, a
// clearing pass marks all pages unused before the first request is accepted.
module size_class_slab_allocator
   import scsa_pkg::*;
#(
   parameter int PAGE_COUNT = 64
) (
   input  logic clock,
   input  logic reset,
   scsa_req_if.sink   req,
   scsa_rsp_if.source rsp,
   scsa_csr_if.sink   csr
);
   localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int PR_W = 1 + CLASS_W + 2*SLOT_W + PW + 1;

   typedef struct packed {
      logic             in_use;
      logic [CLASS_W-1:0] cls;
      logic [SLOT_W-1:0] cnt;
      logic [SLOT_W-1:0] head;
      logic [PW-1:0]     link;
      logic              link_nil;
   } page_rec_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_WALK_RD, S_WALK_CHK, S_POP_RD, S_POP_WR,
      S_SCAN_RD, S_SCAN_CHK, S_THREAD, S_FREE_CHK, S_FREE_WR,
      S_REL_RD, S_REL_CHK, S_REL_PREV_RD, S_REL_PREV_WR, S_RESP
   } state_type;

   state_type state_ff;

   // page record RAM
   logic pr_we;
   logic [PW-1:0] pr_addr;
   page_rec_type pr_wdata, pr_rdata;
   logic [PR_W-1:0] pr_rraw;

   scsa_ram #(.WIDTH(PR_W), .DEPTH(PAGE_COUNT)) u_page_ram (
      .clock(clock), .we(pr_we), .addr(pr_addr), .wdata(pr_wdata), .rdata(pr_rraw)
   );
   assign pr_rdata = page_rec_type'(pr_rraw);

   // object link RAM
   logic ol_we;
   logic [PW+SLOT_W-1:0] ol_addr;
   logic [SLOT_W-1:0] ol_wdata, ol_rdata;

   scsa_ram #(.WIDTH(SLOT_W), .DEPTH(PAGE_COUNT*128)) u_link_ram (
      .clock(clock), .we(ol_we), .addr(ol_addr), .wdata(ol_wdata), .rdata(ol_rdata)
   );

   // class table in flops (seven entries)
   logic [PW-1:0]   chead_ff [CLASS_COUNT];
   logic            cnil_ff  [CLASS_COUNT];
   logic [CFO_W-1:0] cfo_ff  [CLASS_COUNT];
   logic [SLOT_W-1:0] cwp_ff [CLASS_COUNT];
   logic [THR_W-1:0] thr_ff;

   // working registers
   logic [CLASS_W-1:0] cls_ff;
   logic [PW-1:0]     pg_ff, prev_ff;
   logic              prev_nil_ff;
   logic [PW:0]       guard_ff;
   logic [PW:0]       scan_ff;
   logic [SLOT_W-1:0] obj_ff, k_ff;
   page_rec_type      rec_ff;
   logic [11:0]       off_ff;
   logic [ADDR_W-1:0] ga_ff;
   logic [STATUS_W-1:0] st_ff;
   logic              rel_ff;

   // response output register
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_ga_ff;
   logic [STATUS_W-1:0] rsp_st_ff;
   logic              rsp_rel_ff;

   logic [SLOT_W-1:0] full_c;
   assign full_c = full_count(cls_ff);

   logic [CLASS_W-1:0] req_cls;
   assign req_cls = class_of(req.request_size);
   logic bad_size;
   assign bad_size = (req.request_size == '0) || (req.request_size > MAX_REQUEST);

   logic [ADDR_W-12-1:0] req_page_full;
   assign req_page_full = req.object_address[ADDR_W-1:12];
   logic req_page_ok;
   assign req_page_ok = ({{(32-ADDR_W+12){1'b0}}, req_page_full} < 32'(PAGE_COUNT));
   logic [PW-1:0] req_page;
   assign req_page = PW'(req.object_address[ADDR_W-1:12]);

   logic req_fire, csr_fire, rsp_fire, rsp_load;
   assign req.ready = (state_ff == S_IDLE);
   assign req_fire = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign csr_fire = csr.valid && csr.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid = rsp_valid_ff;
   assign rsp.granted_address = rsp_ga_ff;
   assign rsp.status = rsp_st_ff;
   assign rsp.page_released = rsp_rel_ff;

   // free path decode
   logic [SLOT_W-1:0] free_obj;
   logic free_ok;
   logic [SLOT_W-1:0] cnt_inc;
   logic free_whole;
   logic [SLOT_W:0] wp_next;
   logic free_release;
   assign free_obj = SLOT_W'((off_ff >> MIN_SHIFT) >> pr_rdata.cls);
   assign free_ok = pr_rdata.in_use && (free_obj != '0) &&
                    (pr_rdata.cnt < full_count(pr_rdata.cls));
   assign cnt_inc = rec_ff.cnt + 1'b1;
   assign free_whole = (cnt_inc == full_c);
   assign wp_next = {1'b0, cwp_ff[cls_ff]} + {{SLOT_W{1'b0}}, free_whole};
   assign free_release = (wp_next > {1'b0, thr_ff});

   always_comb begin
      pr_we = 1'b0;
      pr_addr = pg_ff;
      pr_wdata = rec_ff;
      ol_we = 1'b0;
      ol_addr = {pg_ff, obj_ff};
      ol_wdata = rec_ff.head;
      unique case (state_ff)
         S_CLEAR: begin
            pr_we = 1'b1;
            pr_addr = PW'(scan_ff);
            pr_wdata = '0;
         end
         S_IDLE: begin
            pr_addr = (req.mode == MODE_FREE) ? req_page : chead_ff[req_cls];
         end
         S_SCAN_RD: pr_addr = PW'(scan_ff);
         S_REL_PREV_RD: pr_addr = prev_ff;
         S_POP_RD: ol_addr = {pg_ff, rec_ff.head};
         S_POP_WR: begin
            pr_we = 1'b1;
            pr_wdata.head = ol_rdata;
            pr_wdata.cnt = rec_ff.cnt - 1'b1;
         end
         S_FREE_WR: begin
            ol_we = 1'b1;
            pr_we = 1'b1;
            pr_wdata.head = obj_ff;
            pr_wdata.cnt = cnt_inc;
         end
         S_THREAD: begin
            ol_we = 1'b1;
            ol_addr = {pg_ff, k_ff};
            ol_wdata = k_ff - 1'b1;
            pr_we = (k_ff == full_c);
         end
         S_REL_CHK: begin
            pr_we = (pr_rdata.cnt == full_c);
            pr_wdata = pr_rdata;
            pr_wdata.in_use = 1'b0;
         end
         S_REL_PREV_WR: begin
            pr_we = 1'b1;
            pr_addr = prev_ff;
            pr_wdata = pr_rdata;
            pr_wdata.link = rec_ff.link;
            pr_wdata.link_nil = rec_ff.link_nil;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff <= THR_W'(2);
         for (int i = 0; i < CLASS_COUNT; i++) begin
            cnil_ff[i] <= 1'b1;
            cfo_ff[i] <= '0;
            cwp_ff[i] <= '0;
         end
      end else begin
         if (csr_fire) thr_ff <= csr.data;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_ga_ff <= ga_ff;
            rsp_st_ff <= st_ff;
            rsp_rel_ff <= rel_ff;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == (PW+1)'(PAGE_COUNT-1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_fire) begin
                  ga_ff <= '0;
                  rel_ff <= 1'b0;
                  guard_ff <= '0;
                  if (req.mode == MODE_ALLOC) begin
                     cls_ff <= req_cls;
                     if (bad_size) begin
                        st_ff <= ST_BAD_SIZE;
                        state_ff <= S_RESP;
                     end else if (cnil_ff[req_cls]) begin
                        st_ff <= ST_OK;
                        scan_ff <= '0;
                        state_ff <= S_SCAN_RD;
                     end else begin
                        st_ff <= ST_OK;
                        pg_ff <= chead_ff[req_cls];
                        state_ff <= S_WALK_CHK;
                     end
                  end else begin
                     st_ff <= ST_OK;
                     pg_ff <= req_page;
                     off_ff <= req.object_address[11:0];
                     state_ff <= req_page_ok ? S_FREE_CHK : S_RESP;
                  end
               end
            end
            S_WALK_RD: state_ff <= S_WALK_CHK;
            S_WALK_CHK: begin
               rec_ff <= pr_rdata;
               if (pr_rdata.cnt != '0 && pr_rdata.head != '0) begin
                  state_ff <= S_POP_RD;
               end else if (pr_rdata.link_nil || guard_ff == (PW+1)'(PAGE_COUNT-1)) begin
                  scan_ff <= '0;
                  state_ff <= S_SCAN_RD;
               end else begin
                  guard_ff <= guard_ff + 1'b1;
                  pg_ff <= pr_rdata.link;
                  state_ff <= S_WALK_RD;
               end
            end
            S_POP_RD: begin
               obj_ff <= rec_ff.head;
               state_ff <= S_POP_WR;
            end
            S_POP_WR: begin
               if (rec_ff.cnt == full_c && cwp_ff[cls_ff] != '0)
                  cwp_ff[cls_ff] <= cwp_ff[cls_ff] - 1'b1;
               if (cfo_ff[cls_ff] != '0) cfo_ff[cls_ff] <= cfo_ff[cls_ff] - 1'b1;
               ga_ff <= ADDR_W'({pg_ff, 12'd0}) +
                        (ADDR_W'({obj_ff, 5'd0}) << cls_ff);
               state_ff <= S_RESP;
            end
            S_SCAN_RD: begin
               pg_ff <= PW'(scan_ff);
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (!pr_rdata.in_use) begin
                  rec_ff.in_use <= 1'b1;
                  rec_ff.cls <= cls_ff;
                  rec_ff.cnt <= full_c;
                  rec_ff.head <= full_c;
                  rec_ff.link <= chead_ff[cls_ff];
                  rec_ff.link_nil <= cnil_ff[cls_ff];
                  k_ff <= SLOT_W'(1);
                  state_ff <= S_THREAD;
               end else if (scan_ff == (PW+1)'(PAGE_COUNT-1)) begin
                  st_ff <= ST_NO_PAGE;
                  state_ff <= S_RESP;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_THREAD: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == full_c) begin
                  chead_ff[cls_ff] <= pg_ff;
                  cnil_ff[cls_ff] <= 1'b0;
                  cwp_ff[cls_ff] <= cwp_ff[cls_ff] + 1'b1;
                  cfo_ff[cls_ff] <= cfo_ff[cls_ff] + CFO_W'(full_c);
                  state_ff <= S_POP_RD;
               end
            end
            S_FREE_CHK: begin
               rec_ff <= pr_rdata;
               cls_ff <= pr_rdata.cls;
               obj_ff <= free_obj;
               state_ff <= free_ok ? S_FREE_WR : S_RESP;
            end
            S_FREE_WR: begin
               cfo_ff[cls_ff] <= cfo_ff[cls_ff] + 1'b1;
               if (free_whole) cwp_ff[cls_ff] <= cwp_ff[cls_ff] + 1'b1;
               if (free_release) begin
                  pg_ff <= chead_ff[cls_ff];
                  prev_nil_ff <= 1'b1;
                  guard_ff <= '0;
                  state_ff <= S_REL_RD;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_REL_RD: state_ff <= S_REL_CHK;
            S_REL_CHK: begin
               rec_ff <= pr_rdata;
               if (pr_rdata.cnt == full_c) begin
                  rel_ff <= 1'b1;
                  cwp_ff[cls_ff] <= cwp_ff[cls_ff] - 1'b1;
                  cfo_ff[cls_ff] <= (cfo_ff[cls_ff] >= CFO_W'(full_c)) ?
                                    cfo_ff[cls_ff] - CFO_W'(full_c) : '0;
                  if (prev_nil_ff) begin
                     chead_ff[cls_ff] <= pr_rdata.link;
                     cnil_ff[cls_ff] <= pr_rdata.link_nil;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_REL_PREV_RD;
                  end
               end else if (pr_rdata.link_nil || guard_ff == (PW+1)'(PAGE_COUNT-1)) begin
                  state_ff <= S_RESP;
               end else begin
                  guard_ff <= guard_ff + 1'b1;
                  prev_ff <= pg_ff;
                  prev_nil_ff <= 1'b0;
                  pg_ff <= pr_rdata.link;
                  state_ff <= S_REL_RD;
               end
            end
            S_REL_PREV_RD: state_ff <= S_REL_PREV_WR;
            S_REL_PREV_WR: state_ff <= S_RESP;
            S_RESP: begin
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("response dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=>
         $stable({rsp.granted_address, rsp.status, rsp.page_released}))
      else $error("response word changed while waiting");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.page_released |-> rsp.status == ST_OK && rsp.granted_address == '0)
      else $error("release flagged on non-free");
endmodule

[tb/sv/scsa_tb_pkg.sv]
// ----------------------------------------------------------------------------
// scsa_tb_pkg
// Shared testbench constants for the slab allocator environment.
// ----------------------------------------------------------------------------
package scsa_tb_pkg;
   localparam int PAGES = 64;
   localparam int SLOTS = 128;
   localparam int NULL_PAGE = 127;
   localparam int RESET_THRESHOLD = 2;
endpackage

[tb/sv/scsa_checker.sv]
// ----------------------------------------------------------------------------
// scsa_checker
// Watches the request, response and register channels of the slab allocator,
// keeps its own allocator state to predict each response and compares.
// ----------------------------------------------------------------------------
module scsa_checker
   import scsa_pkg::*;
   import scsa_tb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic req_mode,
   input  logic [SIZE_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_object_address,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [ADDR_W-1:0] rsp_granted_address,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic rsp_page_released,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [THR_W-1:0] csr_data,
   output int   mismatch_count,
   output int   pending_count
);
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [STATUS_W-1:0] status;
      logic released;
   } alloc_rsp_type;

   alloc_rsp_type expected_rsps[$];

   bit         in_use[PAGES];
   int         cls[PAGES];
   int         free_cnt[PAGES];
   int         free_head[PAGES];
   int         next_page[PAGES];
   int         obj_next[PAGES*SLOTS];
   int         head[CLASS_COUNT];
   int         free_objs[CLASS_COUNT];
   int         whole_pages[CLASS_COUNT];
   int         threshold;

   function automatic int slots_of(int c);
      return (4096 >> (c + MIN_SHIFT)) - 1;
   endfunction

   function automatic alloc_rsp_type predict_alloc(int size);
      alloc_rsp_type r;
      int c, span, p, guard, obj, n;
      bit found;
      r = '0;
      if (size == 0 || size > 2048) begin
         r.status = ST_BAD_SIZE;
         return r;
      end
      c = 0;
      span = 32;
      while (span < size) begin
         span = span << 1;
         c++;
      end
      found = 0;
      guard = 0;
      p = head[c];
      while (p != NULL_PAGE && guard < PAGES) begin
         if (free_cnt[p] > 0 && free_head[p] != 0) begin
            found = 1;
            break;
         end
         p = next_page[p];
         guard++;
      end
      if (!found) begin
         for (p = 0; p < PAGES; p++)
            if (!in_use[p]) break;
         if (p >= PAGES) begin
            r.status = ST_NO_PAGE;
            return r;
         end
         n = slots_of(c);
         in_use[p] = 1;
         cls[p] = c;
         free_cnt[p] = n;
         for (int k = 1; k <= n; k++) obj_next[p*SLOTS+k] = k - 1;
         free_head[p] = n;
         next_page[p] = head[c];
         head[c] = p;
         whole_pages[c]++;
         free_objs[c] = (free_objs[c] + n) & 13'h1fff;
      end
      obj = free_head[p];
      free_head[p] = obj_next[p*SLOTS+obj];
      if (free_cnt[p] == slots_of(c) && whole_pages[c] > 0) whole_pages[c]--;
      free_cnt[p]--;
      if (free_objs[c] > 0) free_objs[c]--;
      r.addr = ADDR_W'(p*4096 + (obj << (c + MIN_SHIFT)));
      return r;
   endfunction

   function automatic alloc_rsp_type predict_free(int addr);
      alloc_rsp_type r;
      int p, c, obj, full, q, prev, guard;
      r = '0;
      p = addr / 4096;
      if (p >= PAGES || !in_use[p]) return r;
      c = cls[p];
      full = slots_of(c);
      obj = (addr % 4096) >> (c + MIN_SHIFT);
      if (obj == 0 || free_cnt[p] >= full) return r;
      obj_next[p*SLOTS+obj] = free_head[p];
      free_head[p] = obj;
      free_cnt[p]++;
      free_objs[c] = (free_objs[c] + 1) & 13'h1fff;
      if (free_cnt[p] == full) whole_pages[c]++;
      if (whole_pages[c] <= threshold) return r;
      prev = NULL_PAGE;
      q = head[c];
      guard = 0;
      while (q != NULL_PAGE && guard < PAGES) begin
         if (free_cnt[q] == full) begin
            if (prev == NULL_PAGE) head[c] = next_page[q];
            else next_page[prev] = next_page[q];
            whole_pages[c]--;
            free_objs[c] = free_objs[c] >= full ? free_objs[c] - full : 0;
            in_use[q] = 0;
            r.released = 1'b1;
            return r;
         end
         prev = q;
         q = next_page[q];
         guard++;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_rsp_type e;
      if (reset) begin
         for (int i = 0; i < PAGES; i++) in_use[i] = 0;
         for (int i = 0; i < CLASS_COUNT; i++) begin
            head[i] = NULL_PAGE;
            free_objs[i] = 0;
            whole_pages[i] = 0;
         end
         threshold = RESET_THRESHOLD;
         expected_rsps.delete();
         mismatch_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) threshold = int'(csr_data);
         if (req_valid && req_ready) begin
            if (req_mode == MODE_ALLOC) e = predict_alloc(int'(req_request_size));
            else e = predict_free(int'(req_object_address));
            expected_rsps.push_back(e);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               if (mismatch_count < 10) $display("unexpected response word");
               mismatch_count <= mismatch_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_granted_address !== e.addr || rsp_status !== e.status ||
                   rsp_page_released !== e.released) begin
                  if (mismatch_count < 10)
                     $display("mismatch: exp addr %h st %0d rel %0b, got %h %0d %0b",
                              e.addr, e.status, e.released, rsp_granted_address,
                              rsp_status, rsp_page_released);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         pending_count <= expected_rsps.size();
      end
   end
endmodule

[tb/sv/size_class_slab_allocator_tb.sv]
// ----------------------------------------------------------------------------
// size_class_slab_allocator_tb
// Drives allocate and free traffic, register writes and backpressure into the
// slab allocator; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_tb;
   import scsa_pkg::*;
   import scsa_tb_pkg::*;

   logic clock;
   logic reset;
   int   mismatch_count, pending_count;
   int   cycle_count;
   bit   quiet_phase;
   bit   hold_rsp;
   int   sent_count;
   logic [ADDR_W-1:0] live_addrs[$];

   scsa_req_if req_ch();
   scsa_rsp_if rsp_ch();
   scsa_csr_if csr_ch();

   size_class_slab_allocator #(.PAGE_COUNT(PAGES)) DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr(csr_ch.sink));

   scsa_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_mode(req_ch.mode),
      .req_request_size(req_ch.request_size),
      .req_object_address(req_ch.object_address),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_granted_address(rsp_ch.granted_address), .rsp_status(rsp_ch.status),
      .rsp_page_released(rsp_ch.page_released),
      .csr_valid(csr_ch.valid), .csr_ready(csr_ch.ready), .csr_data(csr_ch.data),
      .mismatch_count(mismatch_count), .pending_count(pending_count));

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 2000000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // record granted words so later frees hit live objects
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
          rsp_ch.granted_address != 0)
         live_addrs.push_back(rsp_ch.granted_address);

   initial begin
      int gap;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_ch.ready <= 0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   task automatic send_word(logic m, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.mode <= m;
      req_ch.request_size <= sz;
      req_ch.object_address <= a;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic idle_req();
      req_ch.valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_count != 0)
         @(posedge clock);
      repeat (420) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] v);
      idle_req();
      drain();
      csr_ch.valid <= 1;
      csr_ch.data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 0;
   endtask

   task automatic random_word();
      int r, i;
      logic [ADDR_W-1:0] a;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0: send_word(MODE_ALLOC, SIZE_W'($urandom_range(1, 64)), ADDR_W'($urandom));
            1: send_word(MODE_ALLOC, SIZE_W'($urandom_range(1, 2048)), ADDR_W'($urandom));
            2: send_word(MODE_ALLOC, 16'(32 << $urandom_range(0, 6)), ADDR_W'($urandom));
            default: send_word(MODE_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom));
         endcase
      end else if (r < 92 && live_addrs.size() > 0) begin
         i = $urandom_range(0, live_addrs.size() - 1);
         a = live_addrs[i];
         live_addrs.delete(i);
         if ($urandom_range(0, 9) == 0) a = ADDR_W'(a + $urandom_range(1, 31));
         send_word(MODE_FREE, SIZE_W'($urandom), a);
      end else begin
         send_word(MODE_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
      end
   endtask

   initial begin
      reset = 1;
      quiet_phase = 0;
      hold_rsp = 0;
      sent_count = 0;
      req_ch.valid = 0;
      req_ch.mode = MODE_ALLOC;
      req_ch.request_size = 0;
      req_ch.object_address = 0;
      csr_ch.valid = 0;
      csr_ch.data = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_word(MODE_ALLOC, 16'd0, '0);
      send_word(MODE_ALLOC, 16'hffff, '1);
      send_word(MODE_ALLOC, 16'd2049, '0);
      send_word(MODE_ALLOC, 16'd1, '0);
      send_word(MODE_ALLOC, 16'd32, '0);
      send_word(MODE_ALLOC, 16'd33, '0);
      send_word(MODE_ALLOC, 16'd128, '0);
      send_word(MODE_ALLOC, 16'd256, '0);
      send_word(MODE_ALLOC, 16'd512, '0);
      send_word(MODE_ALLOC, 16'd1024, '0);
      send_word(MODE_ALLOC, 16'd2048, '0);
      send_word(MODE_FREE, '1, 18'h3ffff);
      send_word(MODE_FREE, '0, 18'h3f000);
      send_word(MODE_FREE, '0, 18'h00000);
      send_word(MODE_FREE, '0, 18'h00020);
      send_word(MODE_FREE, '0, 18'h00020);
      send_word(MODE_FREE, '0, 18'h00c7f);
      send_word(MODE_FREE, '0, 18'h00c00);
      send_word(MODE_FREE, '0, 18'h01800);

      write_threshold(7'd0);
      repeat (90) random_word();
      write_threshold(7'd127);
      // exhaust the pool with large objects
      repeat (70) send_word(MODE_ALLOC, 16'd2048, '0);
      repeat (60) random_word();
      write_threshold(7'd64);
      hold_rsp = 1;
      repeat (100) random_word();
      write_threshold(7'd1);
      repeat (150) random_word();
      write_threshold(7'd2);
      repeat (100) random_word();
      quiet_phase = 1;
      repeat (60) random_word();
      idle_req();
      drain();

      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
